@@ sv/lobm_pkg.sv @@
// Shared types and constants of the limit order book matcher.
package lobm_pkg;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 240;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [1:0] {
    KIND_TRADE    = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

endpackage

@@ sv/lobm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/limit_order_book_matcher_core.sv @@
// Limit order book matcher core: price-time priority matching over a RAM-held book.
// Orders arrive one at a time and the block takes a new order only when the previous
// one has fully finished. For each trade the matcher sweeps the n resting orders
// through the book RAM (one read per cycle), emits the trade beat, and when the resting
// order is used up compacts the book by moving each younger entry down one slot (a
// read state, then a write state, per moved entry). A last sweep, when quantity is
// left, and the closing beat end the order; output stalls hold the trade and closing
// states. No clearing pass is needed after reset: an entry count marks which slots
// hold orders.
module limit_order_book_matcher_core
  import lobm_pkg::*;
#(
  parameter int unsigned MAX_RESTING = 32,
  parameter int unsigned PRICE_BITS  = 16,
  parameter int unsigned QTY_BITS    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // limit_price[15:0], amount[47:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // side[0], order_kind[1]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // new_order_id[31:0], buyer_id[63:32], seller_id[95:64], fill_price[111:96],
  // fill_amount[143:112], left_amount[175:144], volume_total[239:176]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // kind[1:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  localparam int unsigned PW = (PRICE_BITS < 16) ? PRICE_BITS : 16;
  localparam int unsigned QW = (QTY_BITS < 32) ? QTY_BITS : 32;
  localparam int unsigned EW = 1 + PW + QW + 32;
  localparam int unsigned IW = $clog2(MAX_RESTING);
  localparam int unsigned CW = $clog2(MAX_RESTING + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TRADE, S_SH_RD, S_SH_WR, S_DONE
  } state_e;

  state_e          state_q;
  logic            side_q, mkt_q, rej_q;
  logic [PW-1:0]   price_q;
  logic [QW-1:0]   rem_q;
  logic [31:0]     oid_q, id_q;
  logic [63:0]     vol_q;
  logic [CW-1:0]   cnt_q, idx_q;
  logic            pend_q, found_q;
  logic [IW-1:0]   best_idx_q, sh_q;
  logic [PW-1:0]   best_px_q;
  logic [QW-1:0]   best_rem_q;
  logic [31:0]     best_oid_q;

  logic            ov_q, ov_d, out_load, olast_q;
  kind_e           okind_q;
  logic [31:0]     ooid_q, obuy_q, osell_q, ofill_q, oleft_q;
  logic [15:0]     opx_q;
  logic [63:0]     ovol_q;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;

  logic            e_side;
  logic [PW-1:0]   e_px;
  logic [QW-1:0]   e_rem;
  logic [31:0]     e_oid;
  logic            ren, out_free, better, px_ok;
  logic [QW-1:0]   q, rem_left, slot_left;
  logic [CW:0]     sh_next2, best_next;

  assign e_side = rdata[EW-1];
  assign e_px   = rdata[EW-2 -: PW];
  assign e_rem  = rdata[QW+31:32];
  assign e_oid  = rdata[31:0];

  assign ren       = (idx_q < cnt_q);
  assign out_free  = !ov_q || m_axis_tready_i;
  assign better    = !side_q ? (e_px < best_px_q) : (e_px > best_px_q);
  assign px_ok     = mkt_q || (!side_q ? (price_q >= best_px_q) : (price_q <= best_px_q));
  assign q         = (rem_q < best_rem_q) ? rem_q : best_rem_q;
  assign rem_left  = rem_q - q;
  assign slot_left = best_rem_q - q;
  assign sh_next2  = (CW+1)'(sh_q) + (CW+1)'(2);
  assign best_next = (CW+1)'(best_idx_q) + (CW+1)'(1);

  // load a new beat from the trade or closing state, otherwise hold until taken
  assign out_load = ((state_q == S_TRADE) || (state_q == S_DONE)) && out_free;
  assign ov_d     = out_load || (ov_q && !m_axis_tready_i);

  always_comb begin
    we    = 1'b0;
    waddr = best_idx_q;
    wdata = {best_oid_q[0], best_px_q, slot_left, best_oid_q} & '0;
    raddr = idx_q[IW-1:0];
    unique case (state_q)
      S_TRADE: begin
        we    = out_free && (slot_left != '0);
        waddr = best_idx_q;
        wdata = {!side_q, best_px_q, slot_left, best_oid_q};
      end
      S_SH_RD: raddr = IW'(sh_q + IW'(1));
      S_SH_WR: begin
        we    = 1'b1;
        waddr = sh_q;
        wdata = rdata;
      end
      S_DONE: begin
        we    = out_free && !rej_q && (rem_q != '0) && !mkt_q && (cnt_q < CW'(MAX_RESTING));
        waddr = cnt_q[IW-1:0];
        wdata = {side_q, price_q, rem_q, oid_q};
      end
      default: ;
    endcase
  end

  lobm_ram #(.WIDTH(EW), .DEPTH(MAX_RESTING)) u_book (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      id_q    <= 32'd1;
      vol_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      rej_q   <= 1'b0;
    end else begin
      ov_q <= ov_d;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            side_q  <= s_axis_tuser_i[0];
            mkt_q   <= s_axis_tuser_i[1];
            price_q <= PW'(s_axis_tdata_i[15:0]);
            rem_q   <= QW'(s_axis_tdata_i[47:16]);
            idx_q   <= '0;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            if ((QW'(s_axis_tdata_i[47:16]) == '0) ||
                (!s_axis_tuser_i[1] && (PW'(s_axis_tdata_i[15:0]) == '0))) begin
              rej_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              rej_q   <= 1'b0;
              oid_q   <= id_q;
              id_q    <= id_q + 32'd1;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ren) begin
            idx_q <= idx_q + CW'(1);
          end
          pend_q     <= ren;
          sh_q       <= idx_q[IW-1:0];
          // sh_q doubles as the index of the entry whose data returns this cycle
          if (pend_q && (e_side != side_q) && (!found_q || better)) begin
            found_q    <= 1'b1;
            best_idx_q <= sh_q;
            best_px_q  <= e_px;
            best_rem_q <= e_rem;
            best_oid_q <= e_oid;
          end
          if (!ren && !pend_q) begin
            state_q <= (found_q && px_ok) ? S_TRADE : S_DONE;
          end
        end
        S_TRADE: begin
          if (out_free) begin
            okind_q <= KIND_TRADE;
            olast_q <= 1'b0;
            ooid_q  <= oid_q;
            obuy_q  <= side_q ? best_oid_q : oid_q;
            osell_q <= side_q ? oid_q : best_oid_q;
            opx_q   <= 16'(best_px_q);
            ofill_q <= 32'(q);
            oleft_q <= 32'(rem_left);
            ovol_q  <= vol_q + 64'(q);
            vol_q   <= vol_q + 64'(q);
            rem_q   <= rem_left;
            idx_q   <= '0;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            sh_q    <= best_idx_q;
            if (slot_left != '0) begin
              state_q <= (rem_left != '0) ? S_SCAN : S_DONE;
            end else if (best_next < (CW+1)'(cnt_q)) begin
              state_q <= S_SH_RD;
            end else begin
              cnt_q   <= cnt_q - CW'(1);
              state_q <= (rem_left != '0) ? S_SCAN : S_DONE;
            end
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          // move one younger entry down, then close the gap at the top
          sh_q <= IW'(sh_q + IW'(1));
          if (sh_next2 < (CW+1)'(cnt_q)) begin
            state_q <= S_SH_RD;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= (rem_q != '0) ? S_SCAN : S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            olast_q <= 1'b1;
            obuy_q  <= '0;
            osell_q <= '0;
            opx_q   <= '0;
            ofill_q <= '0;
            oleft_q <= 32'(rem_q);
            ovol_q  <= vol_q;
            ooid_q  <= rej_q ? 32'd0 : oid_q;
            if (rej_q) begin
              okind_q <= KIND_REJECTED;
            end else if ((rem_q != '0) && !mkt_q) begin
              if (cnt_q < CW'(MAX_RESTING)) begin
                okind_q <= KIND_DONE;
                cnt_q   <= cnt_q + CW'(1);
              end else begin
                okind_q <= KIND_FULL;
              end
            end else begin
              okind_q <= KIND_DONE;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {ovol_q, oleft_q, ofill_q, opx_q, osell_q, obuy_q, ooid_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RESTING))
    else $error("book count exceeds capacity");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !we)
    else $error("book written during scan");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
    (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("book count jumped");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q != S_IDLE))
    else $error("accepted beat left no work");

endmodule
